/* design/svm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// shared types and codes of the stack machine executor: channel payloads,
// instruction and status codes, controller to datapath command and status
// ----------------------------------------------------------------------------
package svm_pkg;

	// instruction codes, anything above nop is unsupported
	typedef enum logic [3:0] {
		ACT_START  = 4'd0,
		ACT_I32    = 4'd1,
		ACT_I64    = 4'd2,
		ACT_ADD    = 4'd3,
		ACT_SUB    = 4'd4,
		ACT_MUL    = 4'd5,
		ACT_LGET   = 4'd6,
		ACT_LSET   = 4'd7,
		ACT_RETURN = 4'd8,
		ACT_DROP   = 4'd9,
		ACT_NOP    = 4'd10
	} action_e;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_RETURN      = 3'd1,
		ST_OVERFLOW    = 3'd2,
		ST_UNDERFLOW   = 3'd3,
		ST_RANGE       = 3'd4,
		ST_UNSUPPORTED = 3'd5,
		ST_IGNORED     = 3'd6
	} status_e;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_ALLOC_EN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGS_IN_USE = 4'd1;
	localparam logic REG_ALLOC_EN_RST = 1'b1;
	localparam logic [5:0] REGS_IN_USE_RST = 6'd32;

	localparam int DEPTH_FIELD_W = 12;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [63:0] immediate;
		logic [15:0]        local_index;
	} instr_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [DEPTH_FIELD_W-1:0] stack_depth;
		logic [63:0]               top_value;
	} result_t;

	typedef enum logic [1:0] {
		RD_BELOW2,
		RD_TOP,
		RD_IDX
	} rd_sel_e;

	typedef enum logic {
		WA_SP,
		WA_IDX
	} wa_sel_e;

	typedef enum logic [2:0] {
		WD_IMM32,
		WD_IMM64,
		WD_ALU,
		WD_RDATA,
		WD_LREG,
		WD_TOS
	} wd_sel_e;

	typedef enum logic [1:0] {
		SP_HOLD,
		SP_INC,
		SP_DEC,
		SP_DEC2
	} sp_op_e;

	typedef enum logic [1:0] {
		TOS_HOLD,
		TOS_WDATA,
		TOS_RDATA
	} tos_sel_e;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_e;

	typedef struct packed {
		logic     load_instr;
		logic     rd_en;
		rd_sel_e  rd_sel;
		logic     wr_en;
		wa_sel_e  wa_sel;
		wd_sel_e  wd_sel;
		sp_op_e   sp_op;
		tos_sel_e tos_sel;
		logic     alu_load;
		alu_op_e  alu_op;
		logic     lreg_wr;
		logic     res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic sp_zero;
		logic sp_one;
		logic sp_full;
		logic in_regs;
		logic idx_range;
	} dp_stat_t;

endpackage

/* design/svm_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm channel interfaces
// valid/ready channels for instructions, results and configuration writes
// ----------------------------------------------------------------------------
interface svm_instr_if;
	logic            valid;
	logic            ready;
	svm_pkg::instr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svm_result_if;
	logic             valid;
	logic             ready;
	svm_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [svm_pkg::CFG_IDX_W-1:0]  index;
	logic [svm_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

/* design/svm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module svm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/svm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl
// instruction sequencer: decodes, checks the run state and walks the
// datapath through the memory accesses of one instruction
// ----------------------------------------------------------------------------
module svm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [3:0]         in_action,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         out_status,
	input  svm_pkg::dp_stat_t  dp_stat,
	output svm_pkg::dp_cmd_t   dp_cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_OP_WAIT,
		S_OP_PUSH,
		S_GET_WAIT,
		S_TOP_RD,
		S_TOP_WAIT,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RUN_READY,
		RUN_RUNNING,
		RUN_STOPPED,
		RUN_ERROR
	} run_t;

	state_t            state_q, state_d;
	run_t              run_q, run_d;
	logic [3:0]        act_q, act_d;
	svm_pkg::status_e  st_q, st_d;
	logic              exec_q, exec_d;
	logic              out_valid_q, out_valid_d;
	logic [2:0]        res_status_q, res_status_d;
	svm_pkg::dp_cmd_t  cmd;

	always_comb begin
		state_d = state_q;
		run_d = run_q;
		act_d = act_q;
		st_d = st_q;
		exec_d = exec_q;
		res_status_d = res_status_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready = 1'b0;
		cmd = '0;
		cmd.rd_sel = svm_pkg::RD_TOP;
		cmd.wa_sel = svm_pkg::WA_SP;
		cmd.wd_sel = svm_pkg::WD_TOS;
		cmd.sp_op = svm_pkg::SP_HOLD;
		cmd.tos_sel = svm_pkg::TOS_HOLD;
		cmd.alu_op = svm_pkg::ALU_ADD;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_instr = 1'b1;
					act_d = in_action;
					state_d = S_FINISH;
					exec_d = 1'b0;
					if (in_action == svm_pkg::ACT_START) begin
						run_d = RUN_RUNNING;
						st_d = svm_pkg::ST_OK;
					end else if (run_q != RUN_RUNNING) begin
						st_d = svm_pkg::ST_IGNORED;
					end else begin
						exec_d = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				st_d = svm_pkg::ST_OK;
				state_d = S_FINISH;
				case (act_q)
					svm_pkg::ACT_I32, svm_pkg::ACT_I64: begin
						if (dp_stat.sp_full) begin
							st_d = svm_pkg::ST_OVERFLOW;
						end else begin
							cmd.wr_en = 1'b1;
							cmd.wd_sel = (act_q == svm_pkg::ACT_I32) ? svm_pkg::WD_IMM32
								: svm_pkg::WD_IMM64;
							cmd.sp_op = svm_pkg::SP_INC;
							cmd.tos_sel = svm_pkg::TOS_WDATA;
						end
					end
					svm_pkg::ACT_ADD, svm_pkg::ACT_SUB, svm_pkg::ACT_MUL: begin
						if (dp_stat.sp_zero) begin
							st_d = svm_pkg::ST_UNDERFLOW;
						end else if (dp_stat.sp_one) begin
							// first pop succeeds, second fails
							cmd.sp_op = svm_pkg::SP_DEC;
							st_d = svm_pkg::ST_UNDERFLOW;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = svm_pkg::RD_BELOW2;
							state_d = S_OP_WAIT;
						end
					end
					svm_pkg::ACT_LGET: begin
						if (dp_stat.in_regs) begin
							if (dp_stat.sp_full) begin
								st_d = svm_pkg::ST_OVERFLOW;
							end else begin
								cmd.wr_en = 1'b1;
								cmd.wd_sel = svm_pkg::WD_LREG;
								cmd.sp_op = svm_pkg::SP_INC;
								cmd.tos_sel = svm_pkg::TOS_WDATA;
							end
						end else if (dp_stat.idx_range) begin
							st_d = svm_pkg::ST_RANGE;
						end else if (dp_stat.sp_full) begin
							st_d = svm_pkg::ST_OVERFLOW;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = svm_pkg::RD_IDX;
							state_d = S_GET_WAIT;
						end
					end
					svm_pkg::ACT_LSET: begin
						if (dp_stat.sp_zero) begin
							st_d = svm_pkg::ST_UNDERFLOW;
						end else begin
							// value is popped before the index check
							cmd.sp_op = svm_pkg::SP_DEC;
							state_d = S_TOP_RD;
							if (dp_stat.in_regs) begin
								cmd.lreg_wr = 1'b1;
							end else if (dp_stat.idx_range) begin
								st_d = svm_pkg::ST_RANGE;
							end else begin
								cmd.wr_en = 1'b1;
								cmd.wa_sel = svm_pkg::WA_IDX;
								cmd.wd_sel = svm_pkg::WD_TOS;
							end
						end
					end
					svm_pkg::ACT_RETURN: begin
						st_d = svm_pkg::ST_RETURN;
					end
					svm_pkg::ACT_DROP: begin
						if (dp_stat.sp_zero) begin
							st_d = svm_pkg::ST_UNDERFLOW;
						end else begin
							cmd.sp_op = svm_pkg::SP_DEC;
							state_d = S_TOP_RD;
						end
					end
					svm_pkg::ACT_NOP: begin
						st_d = svm_pkg::ST_OK;
					end
					default: begin
						st_d = svm_pkg::ST_UNSUPPORTED;
					end
				endcase
			end
			S_OP_WAIT: begin
				cmd.alu_load = 1'b1;
				case (act_q)
					svm_pkg::ACT_SUB: cmd.alu_op = svm_pkg::ALU_SUB;
					svm_pkg::ACT_MUL: cmd.alu_op = svm_pkg::ALU_MUL;
					default:          cmd.alu_op = svm_pkg::ALU_ADD;
				endcase
				cmd.sp_op = svm_pkg::SP_DEC2;
				state_d = S_OP_PUSH;
			end
			S_OP_PUSH: begin
				cmd.wr_en = 1'b1;
				cmd.wd_sel = svm_pkg::WD_ALU;
				cmd.sp_op = svm_pkg::SP_INC;
				cmd.tos_sel = svm_pkg::TOS_WDATA;
				state_d = S_FINISH;
			end
			S_GET_WAIT: begin
				cmd.wr_en = 1'b1;
				cmd.wd_sel = svm_pkg::WD_RDATA;
				cmd.sp_op = svm_pkg::SP_INC;
				cmd.tos_sel = svm_pkg::TOS_WDATA;
				state_d = S_FINISH;
			end
			S_TOP_RD: begin
				if (dp_stat.sp_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = svm_pkg::RD_TOP;
					state_d = S_TOP_WAIT;
				end
			end
			S_TOP_WAIT: begin
				cmd.tos_sel = svm_pkg::TOS_RDATA;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					out_valid_d = 1'b1;
					res_status_d = 3'(st_q);
					state_d = S_IDLE;
					if (exec_q) begin
						if (st_q == svm_pkg::ST_RETURN) begin
							run_d = RUN_STOPPED;
						end else if (st_q != svm_pkg::ST_OK) begin
							run_d = RUN_ERROR;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_q <= RUN_READY;
			act_q <= '0;
			st_q <= svm_pkg::ST_OK;
			exec_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_status_q <= '0;
		end else begin
			state_q <= state_d;
			run_q <= run_d;
			act_q <= act_d;
			st_q <= st_d;
			exec_q <= exec_d;
			out_valid_q <= out_valid_d;
			res_status_q <= res_status_d;
		end
	end

	assign dp_cmd = cmd;
	assign out_valid = out_valid_q;
	assign out_status = res_status_q;

endmodule

/* design/svm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_datapath
// stack pointer, cached top of stack, local register file, alu, operand
// stack memory and result payload register
// ----------------------------------------------------------------------------
module svm_datapath #(
	parameter int STACK_DEPTH = 2048,
	parameter int NUM_REGS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  svm_pkg::instr_t                 in_data,
	input  logic                            cfg_wr,
	input  logic [svm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [svm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  svm_pkg::dp_cmd_t                dp_cmd,
	output svm_pkg::dp_stat_t               dp_stat,
	output logic [svm_pkg::DEPTH_FIELD_W-1:0] res_depth,
	output logic [63:0]                     res_top
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int DFW = svm_pkg::DEPTH_FIELD_W;

	logic [63:0]     imm_q;
	logic [15:0]     idx_q;
	logic [SPW-1:0]  sp_q;
	logic [63:0]     tos_q;
	logic [31:0]     alu_q;
	logic [63:0]     lregs_q [NUM_REGS];
	logic            alloc_en_q;
	logic [5:0]      regs_in_use_q;
	logic [DFW-1:0]  res_depth_q;
	logic [63:0]     res_top_q;

	logic [SPW-1:0]     sp_m1, sp_m2;
	logic [SPW+DFW-1:0] sp_ext;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [63:0]        wr_data, rd_data, lreg_rd;
	logic [31:0]        alu_a, alu_b;
	logic [31:0]        mul_full;
	logic [31:0]        alu_res;

	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);
	assign sp_ext = {{DFW{1'b0}}, sp_q};
	assign lreg_rd = lregs_q[idx_q[RIW-1:0]];

	assign dp_stat.sp_zero = (sp_q == '0);
	assign dp_stat.sp_one = (sp_q == SPW'(1));
	assign dp_stat.sp_full = (32'(sp_q) >= STACK_DEPTH);
	assign dp_stat.idx_range = (32'(idx_q) >= STACK_DEPTH);
	// register count above the file size acts as the file size
	assign dp_stat.in_regs = alloc_en_q && (32'(idx_q) < 32'(regs_in_use_q))
		&& (32'(idx_q) < NUM_REGS);

	always_comb begin
		case (dp_cmd.rd_sel)
			svm_pkg::RD_BELOW2: rd_addr = sp_m2[AW-1:0];
			svm_pkg::RD_IDX:    rd_addr = idx_q[AW-1:0];
			default:            rd_addr = sp_m1[AW-1:0];
		endcase
	end

	always_comb begin
		case (dp_cmd.wa_sel)
			svm_pkg::WA_IDX: wr_addr = idx_q[AW-1:0];
			default:         wr_addr = sp_q[AW-1:0];
		endcase
	end

	always_comb begin
		case (dp_cmd.wd_sel)
			svm_pkg::WD_IMM32: wr_data = {{32{imm_q[31]}}, imm_q[31:0]};
			svm_pkg::WD_IMM64: wr_data = imm_q;
			svm_pkg::WD_ALU:   wr_data = {32'd0, alu_q};
			svm_pkg::WD_RDATA: wr_data = rd_data;
			svm_pkg::WD_LREG:  wr_data = lreg_rd;
			default:           wr_data = tos_q;
		endcase
	end

	// second operand is the cached top, first comes from memory
	assign alu_a = rd_data[31:0];
	assign alu_b = tos_q[31:0];
	assign mul_full = alu_a * alu_b;

	always_comb begin
		case (dp_cmd.alu_op)
			svm_pkg::ALU_SUB: alu_res = alu_a - alu_b;
			svm_pkg::ALU_MUL: alu_res = mul_full;
			default:          alu_res = alu_a + alu_b;
		endcase
	end

	svm_ram #(
		.WIDTH(64),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (dp_cmd.wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (dp_cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			alloc_en_q <= svm_pkg::REG_ALLOC_EN_RST;
			regs_in_use_q <= svm_pkg::REGS_IN_USE_RST;
			for (int i = 0; i < NUM_REGS; i++) begin
				lregs_q[i] <= '0;
			end
		end else begin
			case (dp_cmd.sp_op)
				svm_pkg::SP_INC:  sp_q <= sp_q + SPW'(1);
				svm_pkg::SP_DEC:  sp_q <= sp_m1;
				svm_pkg::SP_DEC2: sp_q <= sp_m2;
				default:          sp_q <= sp_q;
			endcase
			if (cfg_wr && cfg_index == svm_pkg::CFG_REG_ALLOC_EN) begin
				alloc_en_q <= cfg_wdata[0];
			end
			if (cfg_wr && cfg_index == svm_pkg::CFG_REGS_IN_USE) begin
				regs_in_use_q <= cfg_wdata[5:0];
			end
			if (dp_cmd.lreg_wr) begin
				lregs_q[idx_q[RIW-1:0]] <= tos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_instr) begin
			imm_q <= in_data.immediate;
			idx_q <= in_data.local_index;
		end
		case (dp_cmd.tos_sel)
			svm_pkg::TOS_WDATA: tos_q <= wr_data;
			svm_pkg::TOS_RDATA: tos_q <= rd_data;
			default:            tos_q <= tos_q;
		endcase
		if (dp_cmd.alu_load) begin
			alu_q <= alu_res;
		end
		if (dp_cmd.res_load) begin
			res_depth_q <= sp_ext[DFW-1:0];
			res_top_q <= (sp_q == '0) ? 64'd0 : tos_q;
		end
	end

	assign res_depth = res_depth_q;
	assign res_top = res_top_q;

endmodule

/* design/stack_vm_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor
// stack machine that executes one instruction per input transfer and
// returns one result transfer per instruction
// ----------------------------------------------------------------------------
// usage
// - instr: one transfer per instruction (action, immediate, local_index)
// - result: one transfer per instruction (status, stack_depth, top_value)
// - cfg: register writes, always ready; write only while the block is idle
// - one instruction at a time: instr.ready is high only while the sequencer
//   waits for work, so an instruction runs through its steps, ending with
//   the finish step, before the next possible transfer
//   start and ignored instructions: finish only
//   return, nop, constant push, register local get, decode errors: execute
//   memory local get: execute, read wait
//   drop or local set that empties the stack: execute, top read
//   any other drop or local set: execute, top read, top wait
//   add/sub/mul: execute, operand wait, push
// - the steps follow from the registered single read port of the operand
//   stack memory; after a pop the new top is read back into the top register
// - a result that is not taken stays in the output register; the next
//   instruction is still accepted and worked on, and waits in its final
//   step until the output register frees up
// - reset clears the stack pointer, local registers and run state; the
//   stack memory is not cleared
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor #(
	parameter int STACK_DEPTH = 2048,
	parameter int NUM_REGS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	svm_instr_if.sink    instr,
	svm_result_if.source result,
	svm_cfg_if.sink      cfg
);

	// control and status between sequencer and datapath
	svm_pkg::dp_cmd_t  dp_cmd;
	svm_pkg::dp_stat_t dp_stat;

	logic [2:0]                            res_status;
	logic [svm_pkg::DEPTH_FIELD_W-1:0]     res_depth;
	logic [63:0]                           res_top;
	logic                                  cfg_wr;

	// configuration writes never stall
	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid;

	// sequencer: decode, run state, memory access order, output valid
	svm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (instr.valid),
		.in_action  (instr.data.action),
		.in_ready   (instr.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_status (res_status),
		.dp_stat    (dp_stat),
		.dp_cmd     (dp_cmd)
	);

	// datapath: stack pointer, top register, local registers, stack memory
	svm_datapath #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_REGS   (NUM_REGS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (instr.data),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg.index),
		.cfg_wdata (cfg.wdata),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.res_depth (res_depth),
		.res_top   (res_top)
	);

	// result payload comes straight from the output registers
	assign result.data.status = res_status;
	assign result.data.stack_depth = res_depth;
	assign result.data.top_value = res_top;

endmodule

/* design/svm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker
// port level checks of the stack machine executor, bound to the top level
// ----------------------------------------------------------------------------
module svm_checker #(
	parameter int STACK_DEPTH = 2048
) (
	input logic             clk,
	input logic             arst_n,
	input logic             instr_valid,
	input logic             instr_ready,
	input logic             result_valid,
	input logic             result_ready,
	input svm_pkg::result_t result_data
);

	// one instruction at a time, never two transfers in a row
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_ready |=> !instr_ready)
		else $error("instr ready right after a transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// an empty stack reports a zero top value
	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (STACK_DEPTH < 4096) && (result_data.stack_depth == '0)
		|-> (result_data.top_value == 64'd0))
		else $error("nonzero top value on empty stack");

endmodule

bind stack_vm_instruction_executor svm_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_svm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.instr_valid  (instr.valid),
	.instr_ready  (instr.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

/* tb/tb_stack_vm_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_vm_instruction_executor
// self-checking bench for the stack machine executor: a queue-fed driver
// offers instructions, a clocked monitor compares every result against an
// in-bench model of the machine, with config changes between drained phases
// ----------------------------------------------------------------------------
module tb_stack_vm_instruction_executor;

	localparam int STACK_WORDS = 2048;
	localparam int REG_COUNT = 32;
	localparam int IDLE_PCT = 21;
	localparam int HOLD_CYCLES = 80;
	localparam longint LIMIT_NS = 64'd5_000_000;

	// instruction codes beyond nop, all unsupported
	localparam logic [3:0] ACT_BAD_FIRST = 4'd11;
	localparam logic [3:0] ACT_BAD_LAST = 4'd15;
	// register index that maps to nothing
	localparam logic [svm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd2;

	typedef enum logic [1:0] {
		VM_READY,
		VM_RUNNING,
		VM_STOPPED,
		VM_ERROR
	} vm_state_e;

	// one instruction together with the result the model gives for it
	typedef struct packed {
		svm_pkg::instr_t  ins;
		svm_pkg::result_t res;
	} job_t;

	logic clk = 1'b0;
	logic arst_n;

	svm_instr_if  instr_ch ();
	svm_result_if result_ch ();
	svm_cfg_if    cfg_ch ();

	stack_vm_instruction_executor #(
		.STACK_DEPTH(STACK_WORDS),
		.NUM_REGS(REG_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// machine model: operand stack, locals, run state and config copy
	// ------------------------------------------------------------------
	logic [63:0] vm_stack [STACK_WORDS];
	bit          vm_written [STACK_WORDS];
	logic [63:0] vm_locals [REG_COUNT];
	int          vm_sp;
	vm_state_e   vm_state;
	bit          vm_alloc_en;
	logic [5:0]  vm_regs_use;

	job_t             instr_backlog[$];   // instructions not yet offered
	svm_pkg::result_t awaited_results[$]; // results of transferred instructions
	job_t             cur_job;
	bit               instr_taken;
	int               items_issued;
	int               results_seen;
	int               mismatches;
	bit               quiet_phase;
	bit               hold_request;
	int               hold_left;

	function automatic void model_reset();
		for (int i = 0; i < STACK_WORDS; i++) begin
			vm_stack[i] = '0;
			vm_written[i] = 1'b0;
		end
		for (int i = 0; i < REG_COUNT; i++)
			vm_locals[i] = '0;
		vm_sp = 0;
		vm_state = VM_READY;
		vm_alloc_en = svm_pkg::REG_ALLOC_EN_RST;
		vm_regs_use = svm_pkg::REGS_IN_USE_RST;
	endfunction

	function automatic bit push_entry(input logic [63:0] v);
		if (vm_sp >= STACK_WORDS)
			return 1'b0;
		vm_stack[vm_sp] = v;
		vm_written[vm_sp] = 1'b1;
		vm_sp++;
		return 1'b1;
	endfunction

	function automatic bit pop_entry(output logic [63:0] v);
		v = '0;
		if (vm_sp == 0)
			return 1'b0;
		vm_sp--;
		v = vm_stack[vm_sp];
		return 1'b1;
	endfunction

	// register count above the file size acts as the file size
	function automatic bit held_in_regs(input logic [15:0] idx);
		int n;
		n = (vm_regs_use > REG_COUNT) ? REG_COUNT : int'(vm_regs_use);
		return vm_alloc_en && idx < n;
	endfunction

	function automatic svm_pkg::status_e run_op(input svm_pkg::instr_t ins);
		logic [63:0] a, b, v;
		logic [31:0] r;
		case (ins.action)
			svm_pkg::ACT_I32: begin
				v = {{32{ins.immediate[31]}}, ins.immediate[31:0]};
				return push_entry(v) ? svm_pkg::ST_OK : svm_pkg::ST_OVERFLOW;
			end
			svm_pkg::ACT_I64:
				return push_entry(ins.immediate) ? svm_pkg::ST_OK : svm_pkg::ST_OVERFLOW;
			svm_pkg::ACT_ADD, svm_pkg::ACT_SUB, svm_pkg::ACT_MUL: begin
				// with one entry the first pop still takes it
				if (!pop_entry(b))
					return svm_pkg::ST_UNDERFLOW;
				if (!pop_entry(a))
					return svm_pkg::ST_UNDERFLOW;
				if (ins.action == svm_pkg::ACT_ADD)
					r = a[31:0] + b[31:0];
				else if (ins.action == svm_pkg::ACT_SUB)
					r = a[31:0] - b[31:0];
				else
					r = a[31:0] * b[31:0];
				return push_entry({32'h0, r}) ? svm_pkg::ST_OK : svm_pkg::ST_OVERFLOW;
			end
			svm_pkg::ACT_LGET: begin
				if (held_in_regs(ins.local_index))
					v = vm_locals[ins.local_index];
				else if (ins.local_index >= STACK_WORDS)
					return svm_pkg::ST_RANGE;
				else
					v = vm_stack[ins.local_index];
				return push_entry(v) ? svm_pkg::ST_OK : svm_pkg::ST_OVERFLOW;
			end
			svm_pkg::ACT_LSET: begin
				// value leaves the stack even when the index is bad
				if (!pop_entry(v))
					return svm_pkg::ST_UNDERFLOW;
				if (held_in_regs(ins.local_index)) begin
					vm_locals[ins.local_index] = v;
					return svm_pkg::ST_OK;
				end
				if (ins.local_index >= STACK_WORDS)
					return svm_pkg::ST_RANGE;
				vm_stack[ins.local_index] = v;
				vm_written[ins.local_index] = 1'b1;
				return svm_pkg::ST_OK;
			end
			svm_pkg::ACT_RETURN: return svm_pkg::ST_RETURN;
			svm_pkg::ACT_DROP:
				return pop_entry(v) ? svm_pkg::ST_OK : svm_pkg::ST_UNDERFLOW;
			svm_pkg::ACT_NOP: return svm_pkg::ST_OK;
			default: return svm_pkg::ST_UNSUPPORTED;
		endcase
	endfunction

	function automatic svm_pkg::result_t execute_instr(input svm_pkg::instr_t ins);
		svm_pkg::result_t res;
		svm_pkg::status_e st;
		if (ins.action == svm_pkg::ACT_START) begin
			vm_state = VM_RUNNING;
			st = svm_pkg::ST_OK;
		end else if (vm_state != VM_RUNNING) begin
			st = svm_pkg::ST_IGNORED;
		end else begin
			st = run_op(ins);
			if (st == svm_pkg::ST_RETURN)
				vm_state = VM_STOPPED;
			else if (st != svm_pkg::ST_OK)
				vm_state = VM_ERROR;
		end
		res.status = st;
		res.stack_depth = vm_sp[svm_pkg::DEPTH_FIELD_W-1:0];
		res.top_value = (vm_sp > 0) ? vm_stack[vm_sp-1] : 64'h0;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// queues one instruction and its predicted result; a local get that
	// would hit a never-written stack entry is steered elsewhere
	function automatic void queue_instr(input logic [3:0] act, input logic [63:0] imm,
			input logic [15:0] idx);
		job_t job;
		if (act == svm_pkg::ACT_LGET && vm_state == VM_RUNNING && !held_in_regs(idx) &&
				idx < STACK_WORDS && !vm_written[idx]) begin
			// every entry below the stack pointer has been pushed once
			if (vm_sp > 0)
				idx = 16'($urandom_range(0, vm_sp - 1));
			else
				idx = 16'($urandom_range(STACK_WORDS, 16'hFFFF));
		end
		job.ins.action = act;
		job.ins.immediate = imm;
		job.ins.local_index = idx;
		job.res = execute_instr(job.ins);
		instr_backlog.push_back(job);
		items_issued++;
	endfunction

	function automatic logic [3:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return svm_pkg::ACT_I64;
		if (r < 35) return svm_pkg::ACT_I32;
		if (r < 41) return svm_pkg::ACT_ADD;
		if (r < 47) return svm_pkg::ACT_SUB;
		if (r < 53) return svm_pkg::ACT_MUL;
		if (r < 68) return svm_pkg::ACT_LGET;
		if (r < 80) return svm_pkg::ACT_LSET;
		if (r < 87) return svm_pkg::ACT_DROP;
		if (r < 91) return svm_pkg::ACT_NOP;
		if (r < 94) return svm_pkg::ACT_RETURN;
		if (r < 97) return svm_pkg::ACT_START;
		return 4'($urandom_range(ACT_BAD_FIRST, ACT_BAD_LAST));
	endfunction

	function automatic logic [63:0] pick_imm();
		case ($urandom_range(0, 15))
			0: return 64'h0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return {$urandom, 32'h8000_0000};
			5: return {$urandom, 32'h7FFF_FFFF};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// register file, stack memory, the bound and the whole index space
	function automatic logic [15:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 16'($urandom_range(0, REG_COUNT + 8));
		if (r < 55 && vm_sp > 0) return 16'($urandom_range(0, vm_sp - 1));
		if (r < 75) return 16'($urandom_range(0, STACK_WORDS - 1));
		if (r < 85) return 16'($urandom_range(STACK_WORDS - 8, STACK_WORDS + 8));
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// mostly running programs: a halted machine is usually restarted
	function automatic void random_items(input int n);
		logic [3:0] act;
		repeat (n) begin
			if (vm_state != VM_RUNNING && $urandom_range(0, 99) < 85)
				act = svm_pkg::ACT_START;
			else
				act = pick_action();
			queue_instr(act, pick_imm(), pick_index());
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t: %s mismatch, got %h, want %h", $time, field, got, want);
	endtask

	task automatic write_cfg(input logic [svm_pkg::CFG_IDX_W-1:0] idx,
			input logic [svm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		// the write lands at this edge, the model follows
		if (idx == svm_pkg::CFG_REG_ALLOC_EN)
			vm_alloc_en = val[0];
		else if (idx == svm_pkg::CFG_REGS_IN_USE)
			vm_regs_use = val[5:0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// all queued instructions transferred and answered, plus a short pause
	task automatic wait_drained();
		do
			@(negedge clk);
		while (results_seen != items_issued);
		repeat (6) @(negedge clk);
	endtask

	// idle machine, new config (upper data bits are don't-care), then a batch
	task automatic run_phase(input bit alloc, input logic [5:0] regs, input int n,
			input bit calm, input bit hold);
		wait_drained();
		write_cfg(svm_pkg::CFG_REG_ALLOC_EN, {$urandom} & ~32'h1 | 32'(alloc));
		write_cfg(svm_pkg::CFG_REGS_IN_USE, {$urandom} & ~32'h3F | 32'(regs));
		@(posedge clk);
		quiet_phase = calm;
		hold_request = hold;
		random_items(n);
	endtask

	function automatic bit sender_idles();
		return !quiet_phase && $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	// ------------------------------------------------------------------
	// instruction driver: offers the backlog at falling edges
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!instr_ch.valid || instr_taken) begin
				instr_taken = 1'b0;
				if (instr_backlog.size() > 0 && !sender_idles()) begin
					cur_job = instr_backlog.pop_front();
					instr_ch.data <= cur_job.ins;
					instr_ch.valid <= 1'b1;
				end else begin
					instr_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result sink: random back-pressure, plus a long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_request) begin
				// sender keeps going, so the block fills up behind the held result
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= quiet_phase || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: records instruction transfers, checks result transfers
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		svm_pkg::result_t want;
		if (arst_n) begin
			if (instr_ch.valid && instr_ch.ready) begin
				awaited_results.push_back(cur_job.res);
				instr_taken = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result", result_ch.data.top_value, '0);
				end else begin
					want = awaited_results.pop_front();
					if (result_ch.data.status !== want.status)
						report_mismatch("status", 64'(result_ch.data.status),
							64'(want.status));
					if (result_ch.data.stack_depth !== want.stack_depth)
						report_mismatch("stack_depth", 64'(result_ch.data.stack_depth),
							64'(want.stack_depth));
					if (result_ch.data.top_value !== want.top_value)
						report_mismatch("top_value", result_ch.data.top_value,
							want.top_value);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		instr_taken = 1'b0;
		items_issued = 0;
		results_seen = 0;
		mismatches = 0;
		quiet_phase = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		model_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset config
		queue_instr(svm_pkg::ACT_NOP, '0, '0);                      // ignored before start
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(svm_pkg::ACT_DROP, '0, '0);                     // empty stack underflow
		queue_instr(svm_pkg::ACT_ADD, '0, '0);                      // ignored after error
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(svm_pkg::ACT_I32, 64'h0123_4567_8000_0000, '0); // sign-extends
		queue_instr(svm_pkg::ACT_I32, 64'hFFFF_FFFF_7FFF_FFFF, '0);
		queue_instr(svm_pkg::ACT_ADD, '0, '0);                      // zero-extended sum
		queue_instr(svm_pkg::ACT_I64, 64'h8000_0000_0000_0000, '0);
		queue_instr(svm_pkg::ACT_I64, 64'h7FFF_FFFF_FFFF_FFFF, '0);
		queue_instr(svm_pkg::ACT_SUB, '0, '0);
		queue_instr(svm_pkg::ACT_I64, '1, '0);
		queue_instr(svm_pkg::ACT_MUL, '0, '0);
		queue_instr(svm_pkg::ACT_LSET, '0, 16'd0);                  // register file
		queue_instr(svm_pkg::ACT_LGET, '0, 16'd31);
		queue_instr(svm_pkg::ACT_LSET, '0, 16'hFFFF);               // pops, then bad index
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(svm_pkg::ACT_LSET, '0, 16'd100);                // memory above the pointer
		queue_instr(svm_pkg::ACT_LGET, '0, 16'd100);
		queue_instr(svm_pkg::ACT_ADD, '0, '0);                      // one entry, ends empty
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(svm_pkg::ACT_LGET, '0, 16'(STACK_WORDS));       // just past the bound
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(ACT_BAD_FIRST, '0, '0);
		queue_instr(svm_pkg::ACT_START, '0, '0);
		queue_instr(svm_pkg::ACT_RETURN, '0, '0);
		queue_instr(svm_pkg::ACT_I32, '1, '0);                      // ignored after return
		queue_instr(svm_pkg::ACT_START, '0, '0);

		// random phases across register settings, extremes included
		run_phase(1'b0, 6'd32, 200, 1'b0, 1'b0);
		run_phase(1'b1, 6'd0, 200, 1'b0, 1'b0);
		run_phase(1'b1, 6'd63, 200, 1'b1, 1'b0);             // no idling on either side
		run_phase(1'b1, 6'd1, 200, 1'b0, 1'b1);              // long receiver hold-off
		wait_drained();
		write_cfg(CFG_IDX_SPARE, $urandom);                  // index with no register
		run_phase(1'b1, 6'($urandom_range(0, 63)), 250, 1'b0, 1'b0);
		run_phase(1'b1, 6'd40, 220, 1'b0, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("missing results", 64'(awaited_results.size()), '0);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
